// ----- hw/rtl/dmc_pkg.sv -----
// dmc_pkg: shared widths, register codes, reset values and a helper for the
// direct-mapped cache hit checker. No dependencies.
package dmc_pkg;

  localparam int ADDR_WIDTH_DEF = 32;
  localparam int MAX_LINES_DEF  = 1024;

  localparam int ADDR_IN_W    = 32;   // address field on the input channel
  localparam int OFFSET_W     = 5;
  localparam int LINE_COUNT_W = 11;
  localparam int CNT_W        = 32;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 72;   // 1 + 32 + 32 bits, padded to bytes

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 1'b1;

  localparam logic [OFFSET_W-1:0]     OFFSET_BITS_RST = 5'd4;
  localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RST  = 11'd1024;

  // Saturating increment of an item counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

// ----- hw/rtl/dmc_mod_unit.sv -----
// dmc_mod_unit: bit-serial restoring remainder, one dividend bit per cycle.
// Standalone; used by direct_mapped_cache_hit_check for the line index.
module dmc_mod_unit #(
  parameter int DVD_W = 32,
  parameter int DIV_W = 11,
  parameter int REM_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,   // nonzero
  output logic             done,      // one-cycle pulse, rem valid from here on
  output logic [REM_W-1:0] rem
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic                busy_r,  busy_nxt;
  logic                done_r,  done_nxt;
  logic [CNT_BITS-1:0] cnt_r,   cnt_nxt;
  logic [DVD_W-1:0]    dvd_r,   dvd_nxt;
  logic [DIV_W-1:0]    div_r,   div_nxt;
  logic [DIV_W-1:0]    rem_r,   rem_nxt;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic [DIV_W:0] div_ext;

  assign div_ext = {1'b0, div_r};
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = trial - div_ext;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(DVD_W);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_nxt = (trial >= div_ext) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[REM_W-1:0];

endmodule

// ----- hw/rtl/dmc_tag_ram.sv -----
// dmc_tag_ram: line store, one write and one registered read port.
// Standalone; each word is {valid, block number}.
module dmc_tag_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data    // holds until the next read
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/direct_mapped_cache_hit_check.sv -----
// direct_mapped_cache_hit_check: top level, control sequencer, counters, output
// register. Depends on dmc_pkg, dmc_mod_unit and dmc_tag_ram.
//
//   channel  direction  handshake              payload
//   in_      in         in_tvalid / in_tready   in_tdata: address
//   out_     out        out_tvalid / out_tready out_tdata: hit, hit_total, miss_total
//   cfg_     in         cfg_wr_en              cfg_index, cfg_wdata
//
// Each item passes through accept, one remainder step per block-number bit in
// dmc_mod_unit, tag read, compare and write back. After reset a clearing pass
// writes every line invalid with in_tready low; config writes are taken meanwhile.
// The result sits in an output register; a new item can be accepted while it
// waits, and only the compare step stalls if the previous result is not taken.
module direct_mapped_cache_hit_check
  import dmc_pkg::*;
#(
  parameter int MAX_LINES  = MAX_LINES_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] address
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] hit, [32:1] hit_total, [64:33] miss_total
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int DW  = $clog2(MAX_LINES + 1);
  localparam int CW  = (DW > LINE_COUNT_W) ? DW : LINE_COUNT_W;
  localparam int MW  = ADDR_WIDTH + 1;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_CMP  = 2'd3;

  logic [1:0]              state_r,   state_nxt;
  logic [IW-1:0]           clr_idx_r, clr_idx_nxt;
  logic [OFFSET_W-1:0]     cfg_offset_r;
  logic [LINE_COUNT_W-1:0] cfg_lines_r;
  logic [ADDR_WIDTH-1:0]   block_r;
  logic [CNT_W-1:0]        hit_cnt_r,  hit_cnt_nxt;
  logic [CNT_W-1:0]        miss_cnt_r, miss_cnt_nxt;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [CNT_W-1:0]        out_hit_tot_r;
  logic [CNT_W-1:0]        out_miss_tot_r;

  logic                  accept;
  logic [ADDR_WIDTH-1:0] addr_ext;
  logic [CW-1:0]         lc_ext;
  logic [CW-1:0]         lc_clamp;
  logic [DW-1:0]         divisor;
  logic                  mod_done;
  logic [IW-1:0]         mod_rem;
  logic                  rd_en;
  logic [MW-1:0]         rd_data;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [MW-1:0]         wr_data;
  logic                  hit_w;
  logic                  out_free;
  logic                  out_load;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_offset_r <= OFFSET_BITS_RST;
      cfg_lines_r  <= LINE_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: cfg_offset_r <= cfg_wdata[OFFSET_W-1:0];
        REG_LINE_COUNT:  cfg_lines_r  <= cfg_wdata[LINE_COUNT_W-1:0];
      endcase
    end
  end

  // Line count in use: zero reads as one, large values clamp to MAX_LINES
  assign lc_ext   = CW'(cfg_lines_r);
  assign lc_clamp = (lc_ext == '0) ? CW'(1) :
                    (lc_ext > CW'(MAX_LINES)) ? CW'(MAX_LINES) : lc_ext;
  assign divisor  = lc_clamp[DW-1:0];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign addr_ext  = ADDR_WIDTH'(in_tdata[ADDR_IN_W-1:0]);

  dmc_mod_unit #(
    .DVD_W (ADDR_WIDTH),
    .DIV_W (DW),
    .REM_W (IW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (addr_ext >> cfg_offset_r),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign rd_en = (state_r == ST_DIV) && mod_done;

  // Read data is held by the RAM while the compare step stalls
  assign hit_w    = rd_data[MW-1] && (rd_data[ADDR_WIDTH-1:0] == block_r);
  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == ST_CMP) && out_free;

  assign wr_en   = (state_r == ST_CLR) || (out_load && !hit_w);
  assign wr_addr = (state_r == ST_CLR) ? clr_idx_r : mod_rem;
  assign wr_data = (state_r == ST_CLR) ? '0 : {1'b1, block_r};

  dmc_tag_ram #(
    .DEPTH (MAX_LINES),
    .WIDTH (MW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (mod_rem),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    unique case (state_r)
      ST_CLR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IW'(MAX_LINES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (hit_w) begin
            hit_cnt_nxt = sat_inc(hit_cnt_r);
          end else begin
            miss_cnt_nxt = sat_inc(miss_cnt_r);
          end
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_idx_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      block_r <= addr_ext >> cfg_offset_r;
    end
    if (out_load) begin
      out_hit_r      <= hit_w;
      out_hit_tot_r  <= hit_cnt_nxt;
      out_miss_tot_r <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_miss_tot_r, out_hit_tot_r, out_hit_r});

  // A hit never touches the miss total, a miss never touches the hit total
  a_hit_keeps_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && hit_w) |=> $stable(miss_cnt_r))
    else $error("miss counter moved on a hit");

  a_miss_keeps_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !hit_w) |=> $stable(hit_cnt_r))
    else $error("hit counter moved on a miss");

  // The remainder unit only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_DIV))
    else $error("remainder done outside the divide step");

  // The clearing pass covers every line before items are taken
  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && $past(state_r) == ST_CLR) |->
      ($past(clr_idx_r) == IW'(MAX_LINES - 1)))
    else $error("clearing pass ended early");

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for direct_mapped_cache_hit_check. Drives address
// items, predicts hit flag and saturating totals with its own tag store, checks each
// result in order. Depends on dmc_pkg and the RTL top level only.
module testbench;
  import dmc_pkg::*;

  localparam int LINES       = 1024;
  localparam int QUIET_LIMIT = 5000;   // clearing pass plus one slow item, several times over
  localparam int SEGMENTS    = 8;
  localparam int SEG_ITEMS   = 92;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] miss_total;
    logic [31:0] hit_total;
    logic        hit;
  } cache_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ACC, ROW_ACC_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wval;
    logic [31:0]           addr;
    logic                  k_hit;
    logic [31:0]           k_hits;
    logic [31:0]           k_misses;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  direct_mapped_cache_hit_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow cache state
  logic [31:0]       line_blk [LINES];
  bit                line_vld [LINES];
  logic [31:0]       hit_cnt;
  logic [31:0]       miss_cnt;
  logic [OFFSET_W-1:0]     off_q;
  logic [LINE_COUNT_W-1:0] lines_q;

  cache_result_t predicted_outcomes [$];

  int errors;
  int quiet_cycles;
  int accesses_sent;
  int hits_seen;
  int writes_done;
  int snd_idle_pct;
  int rcv_stall_pct;

  // Lines in use: zero acts as one, above LINES acts as LINES
  function automatic cache_result_t lookup_and_fill(input logic [31:0] addr);
    logic [31:0]   blk;
    int unsigned   n;
    int unsigned   idx;
    cache_result_t r;
    blk = addr >> off_q;
    n   = (lines_q == 0) ? 1 : ((lines_q > LINES) ? LINES : lines_q);
    idx = blk % n;
    r   = '0;
    r.hit = line_vld[idx] && (line_blk[idx] == blk);
    if (r.hit) begin
      if (hit_cnt != '1) hit_cnt = hit_cnt + 1;
    end else begin
      line_blk[idx] = blk;
      line_vld[idx] = 1'b1;
      if (miss_cnt != '1) miss_cnt = miss_cnt + 1;
    end
    r.hit_total  = hit_cnt;
    r.miss_total = miss_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic push_access(input logic [31:0] addr, input bit typed,
                             input cache_result_t typed_val);
    cache_result_t pred;
    if (snd_idle_pct > 0 && $urandom_range(9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    pred = lookup_and_fill(addr);
    predicted_outcomes.insert(predicted_outcomes.size(), typed ? typed_val : pred);
    accesses_sent++;
  endtask

  // Registers change only with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_OFFSET_BITS) off_q = val[OFFSET_W-1:0];
    else                        lines_q = val;
    writes_done++;
    @(posedge clk);
  endtask

  plan_row_t directed_plan [0:33] = '{
    '{ROW_CFG,       REG_OFFSET_BITS, 11'h7E4, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC_KNOWN, REG_OFFSET_BITS, 11'h000, 32'h0000_0000, 1'b0, 32'd0, 32'd1},
    '{ROW_ACC_KNOWN, REG_OFFSET_BITS, 11'h000, 32'h0000_000F, 1'b1, 32'd1, 32'd1},
    '{ROW_ACC_KNOWN, REG_OFFSET_BITS, 11'h000, 32'hFFFF_FFFF, 1'b0, 32'd1, 32'd2},
    '{ROW_ACC_KNOWN, REG_OFFSET_BITS, 11'h000, 32'h0000_4000, 1'b0, 32'd1, 32'd3},
    '{ROW_ACC_KNOWN, REG_OFFSET_BITS, 11'h000, 32'h0000_0000, 1'b0, 32'd1, 32'd4},
    '{ROW_ACC_KNOWN, REG_OFFSET_BITS, 11'h000, 32'hFFFF_FFF0, 1'b1, 32'd2, 32'd4},
    '{ROW_CFG,       REG_OFFSET_BITS, 11'h000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0001, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0001, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'hAAAA_AAAA, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h5555_5555, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_OFFSET_BITS, 11'h01F, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h8000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h7FFF_FFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_OFFSET_BITS, 11'h004, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_LINE_COUNT,  11'h000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0010, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0020, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_002C, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_LINE_COUNT,  11'h7FF, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_4010, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_4018, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_LINE_COUNT,  11'h003, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0030, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0040, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_003F, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_LINE_COUNT,  11'h401, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h0000_0020, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_LINE_COUNT,  11'h001, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h1234_5670, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'h1234_567F, 1'b0, 32'd0, 32'd0},
    '{ROW_ACC,       REG_OFFSET_BITS, 11'h000, 32'hFEDC_BA90, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,       REG_LINE_COUNT,  11'h400, 32'h0000_0000, 1'b0, 32'd0, 32'd0}
  };

  // Random segments: offset and line count per segment, extremes included
  int seg_off   [SEGMENTS] = '{4, 0, 31, 6, 2, 12, 5, 0};
  int seg_lines [SEGMENTS] = '{16, 1, 1024, 7, 1000, 0, 2047, 0};

  always @(posedge clk) begin : result_check
    cache_result_t got;
    cache_result_t want;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = cache_result_t'(out_tdata);
      if (got.hit) hits_seen++;
      if (predicted_outcomes.size() == 0) begin
        flag_mismatch("unexpected result", {31'd0, got.hit}, 32'd0);
      end else begin
        want = predicted_outcomes.pop_front();
        if (got.hit !== want.hit)
          flag_mismatch("hit", {31'd0, got.hit}, {31'd0, want.hit});
        if (got.hit_total !== want.hit_total)
          flag_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.miss_total !== want.miss_total)
          flag_mismatch("miss_total", got.miss_total, want.miss_total);
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("** direct_mapped_cache_hit_check: FAILED **");
    $finish;
  end

  initial begin : stimulus
    cache_result_t typed_val;
    logic [31:0]   recent [16];
    logic [31:0]   mask;
    logic [31:0]   blk;
    logic [31:0]   seg_base;
    logic [31:0]   addr;
    int            n;
    int            pick;
    int            mode;
    errors        = 0;
    accesses_sent = 0;
    hits_seen     = 0;
    writes_done   = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hit_cnt       = '0;
    miss_cnt      = '0;
    off_q         = OFFSET_BITS_RST;
    lines_q       = LINE_COUNT_RST;
    for (int i = 0; i < LINES; i++) begin
      line_vld[i] = 1'b0;
      line_blk[i] = '0;
    end
    for (int i = 0; i < 16; i++) recent[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; first write lands during the clearing pass
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_reg(directed_plan[i].reg_idx, directed_plan[i].wval);
      end else begin
        typed_val            = '0;
        typed_val.hit        = directed_plan[i].k_hit;
        typed_val.hit_total  = directed_plan[i].k_hits;
        typed_val.miss_total = directed_plan[i].k_misses;
        push_access(directed_plan[i].addr, directed_plan[i].kind == ROW_ACC_KNOWN,
                    typed_val);
      end
    end

    // Random segments, each with its own setting and idling mode
    for (int s = 0; s < SEGMENTS; s++) begin
      if (s == SEGMENTS - 1) begin
        seg_off[s]   = $urandom_range(0, 31);
        seg_lines[s] = $urandom_range(1, 64);
      end
      // junk in the upper data bits of the offset write must be dropped
      write_reg(REG_OFFSET_BITS, {6'($urandom_range(63)), 5'(seg_off[s])});
      write_reg(REG_LINE_COUNT, 11'(seg_lines[s]));
      mode = s % 4;
      snd_idle_pct  = (mode == 1) ? 68 : (mode == 3) ? 34 : 0;
      rcv_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 34 : 0;
      seg_base = $urandom;
      n = (seg_lines[s] == 0) ? 1 : ((seg_lines[s] > LINES) ? LINES : seg_lines[s]);
      if (n > 64) n = 64;   // keep the working set small enough to hit
      mask = (32'd1 << off_q) - 32'd1;
      repeat (SEG_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          addr = (recent[$urandom_range(15)] & ~mask) | ($urandom & mask);
        end else if (pick < 75) begin
          blk  = seg_base + $urandom_range(0, 2 * n + 3);
          addr = (blk << off_q) | ($urandom & mask);
        end else if (pick < 92) begin
          addr = $urandom;
        end else begin
          case ($urandom_range(3))
            0:       addr = 32'h0000_0000;
            1:       addr = 32'hFFFF_FFFF;
            2:       addr = 32'h8000_0000;
            default: addr = 32'h7FFF_FFFF;
          endcase
        end
        recent[$urandom_range(15)] = addr;
        push_access(addr, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d accesses (%0d hits) over %0d register writes,",
             accesses_sent, hits_seen, writes_done);
    $display("offsets 0..31, line counts 0..2047, with and without stalls; %0d errors",
             errors);
    if (errors == 0)
      $display("** direct_mapped_cache_hit_check: PASSED **");
    else
      $display("** direct_mapped_cache_hit_check: FAILED **");
    $finish;
  end

endmodule
